@@ src/gasp_pkg.sv @@
// Package for the glyph atlas skyline packer: sizes, datapath operation codes,
// controller states and the control/status structs.
// No dependencies.
package gasp_pkg;

  localparam int MAX_GLYPHS      = 64;
  localparam int MAX_ATLAS_WIDTH = 1024;
  localparam int SIDE_BITS       = 6;

  localparam int IDX_W   = $clog2(MAX_GLYPHS);
  localparam int CNT_W   = IDX_W + 1;
  localparam int COL_W   = $clog2(MAX_ATLAS_WIDTH);
  localparam int AW_W    = COL_W + 1;
  localparam int LG_W    = $clog2(COL_W + 1);
  localparam int FILL_W  = 11;
  localparam int AREA_W  = 19;
  localparam int EST_W   = AREA_W + 1;
  localparam int SCORE_W = 2 * SIDE_BITS + 1;
  localparam int AH_W    = 12;
  localparam int POS_W   = 10;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_WSTEP, OP_WDONE, OP_CLEAR, OP_ROWTOP, OP_NEXTROW,
    OP_SKIPRD, OP_SKIPSTEP, OP_RUNINIT, OP_RUNRD, OP_RUNSTEP, OP_PICKINIT,
    OP_PICKRD, OP_PICKEV, OP_ADVANCE, OP_PLACE, OP_FILLRD, OP_FILLEV,
    OP_FINISH, OP_OUTRD, OP_OUTEV, OP_DONE
  } dp_op_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_WIDTH, ST_CLEAR, ST_ROW, ST_SKIP_RD, ST_SKIP_EV, ST_RUN_RD,
    ST_RUN_EV, ST_PICK_RD, ST_PICK_EV, ST_PICK_END, ST_FILL_RD, ST_FILL_EV,
    ST_OUT_RD, ST_OUT_EV
  } ctl_state_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic est_gt;    // estimate still above width, width can grow
    logic clr_last;  // last column being cleared
    logic row_end;   // row counter reached atlas height
    logic cx_end;    // scan column at atlas width
    logic fill_gt;   // column read data above current row
    logic run_end;   // free run reached atlas width
    logic pick_end;  // all glyphs scored
    logic found;     // a glyph fits this run
    logic fill_end;  // column update done
    logic out_end;   // all results sent
  } dp_stat_t;

  // Smallest power of two not below v, 0 for 0 and for v above 2048
  function automatic logic [AH_W-1:0] pot_up(input logic [AH_W-1:0] v);
    logic [AH_W-1:0] r;
    r = '0;
    if (v != '0) begin
      for (int k = AH_W - 1; k >= 0; k--) begin
        if ((AH_W'(1) << k) >= v) r = AH_W'(1) << k;
      end
    end
    return r;
  endfunction

endpackage

@@ src/glyph_atlas_skyline_packer.sv @@
// Glyph atlas skyline packer. Loading accepts one glyph per cycle (busy stays low).
// After the last glyph: width search, column clear, then the skyline scan with
// its column reads and glyph picks, then one result beat per glyph, each read
// from the placement store. Results cannot be stalled. Reset is asynchronous
// and active low; it clears the glyph count, area and control state.
module glyph_atlas_skyline_packer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [5:0]  glyph_width_i,
  input  logic [5:0]  glyph_height_i,
  input  logic        last_glyph_i,
  output logic        result_valid_o,
  output logic [5:0]  glyph_number_o,
  output logic [9:0]  pos_x_o,
  output logic [9:0]  pos_y_o,
  output logic        placed_o,
  output logic [10:0] atlas_width_o,
  output logic [11:0] atlas_height_o,
  output logic        last_result_o
);
  import gasp_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     start_ok;

  // accept a beat only while idle
  assign start_ok = start && !busy;

  gasp_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start_ok),
    .last_glyph_i (last_glyph_i),
    .stat_i       (stat),
    .cmd_o        (cmd),
    .busy         (busy)
  );

  gasp_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .glyph_width_i  (glyph_width_i),
    .glyph_height_i (glyph_height_i),
    .result_valid_o (result_valid_o),
    .glyph_number_o (glyph_number_o),
    .pos_x_o        (pos_x_o),
    .pos_y_o        (pos_y_o),
    .placed_o       (placed_o),
    .atlas_width_o  (atlas_width_o),
    .atlas_height_o (atlas_height_o),
    .last_result_o  (last_result_o)
  );

endmodule

@@ src/gasp_ctrl.sv @@
// Packer controller: sequences load, width search, column clear, skyline scan,
// glyph pick, column update and result readout.
// Depends on gasp_pkg.
module gasp_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  logic              last_glyph_i,
  input  gasp_pkg::dp_stat_t stat_i,
  output gasp_pkg::dp_cmd_t  cmd_o,
  output logic              busy
);
  import gasp_pkg::*;

  ctl_state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:     if (start && last_glyph_i) state_d = ST_WIDTH;
      ST_WIDTH:    if (!stat_i.est_gt) state_d = ST_CLEAR;
      ST_CLEAR:    if (stat_i.clr_last) state_d = ST_ROW;
      ST_ROW:      state_d = stat_i.row_end ? ST_OUT_RD : ST_SKIP_RD;
      ST_SKIP_RD:  state_d = stat_i.cx_end ? ST_ROW : ST_SKIP_EV;
      ST_SKIP_EV:  state_d = stat_i.fill_gt ? ST_SKIP_RD : ST_RUN_RD;
      ST_RUN_RD:   state_d = stat_i.run_end ? ST_PICK_RD : ST_RUN_EV;
      ST_RUN_EV:   state_d = stat_i.fill_gt ? ST_PICK_RD : ST_RUN_RD;
      ST_PICK_RD:  state_d = stat_i.pick_end ? ST_PICK_END : ST_PICK_EV;
      ST_PICK_EV:  state_d = ST_PICK_RD;
      ST_PICK_END: state_d = stat_i.found ? ST_FILL_RD : ST_ROW;
      ST_FILL_RD:  state_d = stat_i.fill_end ? ST_ROW : ST_FILL_EV;
      ST_FILL_EV:  state_d = ST_FILL_RD;
      ST_OUT_RD:   state_d = stat_i.out_end ? ST_IDLE : ST_OUT_EV;
      ST_OUT_EV:   state_d = ST_OUT_RD;
      default:     state_d = ST_IDLE;
    endcase
  end

  // datapath command
  always_comb begin
    cmd_o.op = OP_NONE;
    unique case (state_q)
      ST_IDLE:     if (start) cmd_o.op = OP_LOAD;
      ST_WIDTH:    cmd_o.op = stat_i.est_gt ? OP_WSTEP : OP_WDONE;
      ST_CLEAR:    cmd_o.op = OP_CLEAR;
      ST_ROW:      cmd_o.op = stat_i.row_end ? OP_FINISH : OP_ROWTOP;
      ST_SKIP_RD:  cmd_o.op = stat_i.cx_end ? OP_NEXTROW : OP_SKIPRD;
      ST_SKIP_EV:  cmd_o.op = stat_i.fill_gt ? OP_SKIPSTEP : OP_RUNINIT;
      ST_RUN_RD:   cmd_o.op = stat_i.run_end ? OP_PICKINIT : OP_RUNRD;
      ST_RUN_EV:   cmd_o.op = stat_i.fill_gt ? OP_PICKINIT : OP_RUNSTEP;
      ST_PICK_RD:  if (!stat_i.pick_end) cmd_o.op = OP_PICKRD;
      ST_PICK_EV:  cmd_o.op = OP_PICKEV;
      ST_PICK_END: cmd_o.op = stat_i.found ? OP_PLACE : OP_ADVANCE;
      ST_FILL_RD:  if (!stat_i.fill_end) cmd_o.op = OP_FILLRD;
      ST_FILL_EV:  cmd_o.op = OP_FILLEV;
      ST_OUT_RD:   cmd_o.op = stat_i.out_end ? OP_DONE : OP_OUTRD;
      ST_OUT_EV:   cmd_o.op = OP_OUTEV;
      default:     cmd_o.op = OP_NONE;
    endcase
  end

  assign busy = (state_q != ST_IDLE);

endmodule

@@ src/gasp_dpath.sv @@
// Packer datapath: glyph store, column fill memory, placement store, scan
// registers and result ports.
// Depends on gasp_pkg.
module gasp_dpath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  gasp_pkg::dp_cmd_t             cmd_i,
  output gasp_pkg::dp_stat_t            stat_o,
  input  logic [gasp_pkg::SIDE_BITS-1:0] glyph_width_i,
  input  logic [gasp_pkg::SIDE_BITS-1:0] glyph_height_i,
  output logic                          result_valid_o,
  output logic [5:0]                    glyph_number_o,
  output logic [9:0]                    pos_x_o,
  output logic [9:0]                    pos_y_o,
  output logic                          placed_o,
  output logic [10:0]                   atlas_width_o,
  output logic [11:0]                   atlas_height_o,
  output logic                          last_result_o
);
  import gasp_pkg::*;

  // memories
  logic [2*SIDE_BITS-1:0] wh_mem [MAX_GLYPHS];
  logic [FILL_W-1:0]      fill_mem [MAX_ATLAS_WIDTH];
  logic [2*AW_W-1:0]      pl_mem [MAX_GLYPHS];
  logic [2*SIDE_BITS-1:0] wh_q;
  logic [FILL_W-1:0]      rd_q;
  logic [2*AW_W-1:0]      pl_q;

  // control state
  logic [CNT_W-1:0]     cnt_q, i_q;
  logic [AREA_W-1:0]    area_q;
  logic [AW_W-1:0]      aw_q;
  logic [LG_W-1:0]      lg_q;
  logic [AH_W-1:0]      ah_q, ah_out_q;
  logic [AW_W-1:0]      k_q, cx_q, run_q, j_q, jend_q;
  logic [FILL_W-1:0]    cy_q, depth_q, used_h_q, reach_q;
  logic [MAX_GLYPHS-1:0] used_q;
  logic [SCORE_W-1:0]   best_q;
  logic [IDX_W-1:0]     pick_q;
  logic [SIDE_BITS-1:0] bw_q, bh_q;
  logic                 found_q;

  // width estimate: five quarters of the area, shifted by log2 of width
  logic [AREA_W+2:0] area5;
  logic [EST_W-1:0]  est;
  assign area5 = {area_q, 2'b00} + (AREA_W + 3)'(area_q);
  assign est   = area5[AREA_W+2:2] >> lg_q;

  // glyph score
  logic [SIDE_BITS-1:0] cw, ch;
  logic [SCORE_W-1:0]   score;
  logic                 skip;
  assign cw = wh_q[2*SIDE_BITS-1:SIDE_BITS];
  assign ch = wh_q[SIDE_BITS-1:0];
  always_comb begin
    if (FILL_W'(ch) == depth_q) begin
      score = SCORE_W'((SIDE_BITS + 1)'(ch) + 1'b1) * SCORE_W'(cw);
    end else begin
      score = SCORE_W'(ch) + SCORE_W'(cw) + SCORE_W'(1);
    end
  end
  assign skip = used_q[i_q[IDX_W-1:0]] || (AW_W'(cw) > run_q);

  logic [AW_W-1:0] cx_run;
  assign cx_run = cx_q + run_q;

  // status
  assign stat_o.est_gt   = (est > EST_W'(aw_q)) && (aw_q != AW_W'(MAX_ATLAS_WIDTH));
  assign stat_o.clr_last = (k_q == aw_q - AW_W'(1));
  assign stat_o.row_end  = (AH_W'(cy_q) >= ah_q);
  assign stat_o.cx_end   = (cx_q >= aw_q);
  assign stat_o.fill_gt  = (rd_q > cy_q);
  assign stat_o.run_end  = (cx_run >= aw_q);
  assign stat_o.pick_end = (i_q >= cnt_q);
  assign stat_o.found    = found_q;
  assign stat_o.fill_end = (j_q > jend_q) || (j_q >= aw_q);
  assign stat_o.out_end  = (i_q >= cnt_q);

  // column fill memory port controls
  logic              fill_we;
  logic [COL_W-1:0]  fill_wa, fill_ra;
  logic [FILL_W-1:0] fill_wd;
  always_comb begin
    fill_we = 1'b0;
    fill_wa = k_q[COL_W-1:0];
    fill_wd = '0;
    fill_ra = cx_q[COL_W-1:0];
    case (cmd_i.op)
      OP_CLEAR:  fill_we = 1'b1;
      OP_RUNRD:  fill_ra = cx_run[COL_W-1:0];
      OP_FILLRD: fill_ra = j_q[COL_W-1:0];
      OP_FILLEV: begin
        fill_we = (rd_q < reach_q);
        fill_wa = j_q[COL_W-1:0];
        fill_wd = reach_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (fill_we) fill_mem[fill_wa] <= fill_wd;
    rd_q <= fill_mem[fill_ra];
  end

  // glyph size store
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_LOAD && cnt_q < CNT_W'(MAX_GLYPHS)) begin
      wh_mem[cnt_q[IDX_W-1:0]] <= {glyph_width_i, glyph_height_i};
    end
    wh_q <= wh_mem[i_q[IDX_W-1:0]];
  end

  // placement store
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_PLACE) pl_mem[pick_q] <= {cx_q, cy_q};
    pl_q <= pl_mem[i_q[IDX_W-1:0]];
  end

  // scan and bookkeeping registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      area_q   <= '0;
      aw_q     <= AW_W'(1);
      lg_q     <= '0;
      ah_q     <= '0;
      ah_out_q <= '0;
      k_q      <= '0;
      cx_q     <= '0;
      cy_q     <= '0;
      run_q    <= '0;
      j_q      <= '0;
      jend_q   <= '0;
      depth_q  <= '0;
      used_h_q <= '0;
      reach_q  <= '0;
      used_q   <= '0;
      best_q   <= '0;
      pick_q   <= '0;
      bw_q     <= '0;
      bh_q     <= '0;
      found_q  <= 1'b0;
      i_q      <= '0;
    end else begin
      case (cmd_i.op)
        OP_LOAD: begin
          if (cnt_q < CNT_W'(MAX_GLYPHS)) begin
            area_q <= area_q +
                      AREA_W'({1'b0, glyph_width_i} + (SIDE_BITS + 1)'(1)) *
                      AREA_W'({1'b0, glyph_height_i} + (SIDE_BITS + 1)'(1));
            cnt_q  <= cnt_q + CNT_W'(1);
          end
          aw_q <= AW_W'(1);
          lg_q <= '0;
        end
        OP_WSTEP: begin
          aw_q <= aw_q << 1;
          lg_q <= lg_q + LG_W'(1);
        end
        OP_WDONE: begin
          ah_q     <= pot_up(AH_W'(est));
          k_q      <= '0;
          used_q   <= '0;
          cx_q     <= '0;
          cy_q     <= '0;
          used_h_q <= '0;
        end
        OP_CLEAR:   k_q <= k_q + AW_W'(1);
        OP_ROWTOP:  depth_q <= '0;
        OP_NEXTROW: begin
          cx_q <= '0;
          cy_q <= cy_q + FILL_W'(1);
        end
        OP_SKIPSTEP: begin
          if (rd_q - cy_q - FILL_W'(1) > depth_q) depth_q <= rd_q - cy_q - FILL_W'(1);
          cx_q <= cx_q + AW_W'(1);
        end
        OP_RUNINIT: run_q <= AW_W'(1);
        OP_RUNSTEP: run_q <= run_q + AW_W'(1);
        OP_PICKINIT: begin
          i_q     <= '0;
          best_q  <= '0;
          found_q <= 1'b0;
        end
        OP_PICKEV: begin
          if (!skip && score > best_q) begin
            best_q  <= score;
            pick_q  <= i_q[IDX_W-1:0];
            bw_q    <= cw;
            bh_q    <= ch;
            found_q <= 1'b1;
          end
          i_q <= i_q + CNT_W'(1);
        end
        OP_ADVANCE: cx_q <= cx_run;
        OP_PLACE: begin
          used_q[pick_q] <= 1'b1;
          reach_q <= cy_q + FILL_W'(bh_q) + FILL_W'(1);
          if (cy_q + FILL_W'(bh_q) > used_h_q) used_h_q <= cy_q + FILL_W'(bh_q);
          j_q    <= (cx_q == '0) ? '0 : cx_q - AW_W'(1);
          jend_q <= cx_q + AW_W'(bw_q);
        end
        OP_FILLEV: j_q <= j_q + AW_W'(1);
        OP_FINISH: begin
          ah_out_q <= pot_up(AH_W'(used_h_q));
          i_q      <= '0;
        end
        OP_OUTEV: i_q <= i_q + CNT_W'(1);
        OP_DONE: begin
          cnt_q  <= '0;
          area_q <= '0;
          used_q <= '0;
          cx_q   <= '0;
        end
        default: ;
      endcase
    end
  end

  // result beat
  assign result_valid_o = (cmd_i.op == OP_OUTEV);
  assign glyph_number_o = i_q[5:0];
  assign placed_o       = used_q[i_q[IDX_W-1:0]];
  assign pos_x_o        = placed_o ? pl_q[AW_W+POS_W-1:AW_W] : '0;
  assign pos_y_o        = placed_o ? pl_q[POS_W-1:0] : '0;
  assign atlas_width_o  = aw_q;
  assign atlas_height_o = ah_out_q;
  assign last_result_o  = (i_q + CNT_W'(1) == cnt_q);

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_GLYPHS)) else $error("glyph count beyond capacity");
  a_aw_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(aw_q)) else $error("atlas width not a power of two");
  a_cx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cx_q <= aw_q) else $error("scan column past atlas width");
  a_beat_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> i_q < cnt_q) else $error("result beat past glyph count");

endmodule
